@@ rtl/core/framed_mecanum_drive_command_unit_macros.svh @@
// Assertion macros shared by the drive command unit RTL.
`ifndef FRAMED_MECANUM_DRIVE_COMMAND_UNIT_MACROS_SVH
`define FRAMED_MECANUM_DRIVE_COMMAND_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Flag any clock edge at which cond holds.
`define FMDU_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Flag the cycle after ante if cons fails there.
`define FMDU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FMDU_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`define FMDU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/core/fmdu_pkg.sv @@
// Types and constants of the framed mecanum drive command unit.
package fmdu_pkg;

    localparam logic       C_CMD_BYTE       = 1'b0;
    localparam logic       C_CMD_TICK       = 1'b1;

    localparam logic       C_KIND_DRIVE     = 1'b0;
    localparam logic       C_KIND_LOSS      = 1'b1;

    localparam logic       C_REG_SIDE       = 1'b0;
    localparam logic       C_REG_WINDOW     = 1'b1;

    localparam logic       C_SIDE_RIGHT     = 1'b0;
    localparam logic       C_SIDE_LEFT      = 1'b1;

    localparam logic [7:0] C_SYNC_BYTE      = 8'd255;
    // Raw bytes that decode to the lift codes 124 and 123.
    localparam logic [7:0] C_LIFT_UP_BYTE   = 8'd251;
    localparam logic [7:0] C_LIFT_DOWN_BYTE = 8'd250;
    localparam logic [9:0] C_AXIS_BIAS      = 10'd127;
    localparam logic [8:0] C_MAG_LIMIT      = 9'd127;
    localparam logic [7:0] C_LIFT_DUTY_B    = 8'd150;
    localparam logic [3:0] C_WINDOW_RESET   = 4'd9;
    localparam logic [1:0] C_LAST_POS       = 2'd3;

    localparam logic [1:0] C_DIR_OFF        = 2'd0;
    localparam logic [1:0] C_DIR_FWD        = 2'd1;
    localparam logic [1:0] C_DIR_REV        = 2'd2;

    localparam logic [1:0] C_LIFT_OFF       = 2'd0;
    localparam logic [1:0] C_LIFT_UP        = 2'd1;
    localparam logic [1:0] C_LIFT_DOWN      = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [7:0] fwd_byte;
        logic [7:0] lat_byte;
        logic [7:0] rot_byte;
    } t_job;

    typedef struct packed {
        logic              event_kind;
        logic signed [7:0] forward_axis;
        logic signed [7:0] lateral_axis;
        logic signed [7:0] rotation_axis;
        logic        [1:0] motor_a_dir;
        logic        [7:0] motor_a_duty;
        logic        [1:0] motor_b_dir;
        logic        [7:0] motor_b_duty;
        logic        [1:0] lift_drive;
    } t_result;

endpackage

@@ rtl/core/framed_mecanum_drive_command_unit.sv @@
// Top level of the framed mecanum drive command unit.
// The unit takes received serial bytes and 10 ms ticks as beats on a queue-style input
// (push/full) and returns drive commands and link-lost notices on a queue-style output
// (empty/pop). Bytes are assembled into 4-byte frames opening with a 255 sync byte; a
// complete frame gives one drive command, either a lift command (all axes 124 = up,
// 123 = down; drive motors off, motor B duty 150, motor A duty held) or mecanum wheel
// sums for the selected side, direction from the sign and duty twice the magnitude
// clamped at 127. Every window_ticks+1 ticks a window closes and, if no valid frame came
// in it, a link-lost notice is issued unless one was already issued since the last valid
// frame. The unit takes one beat every clock cycle while full is low: the front end
// classifies each beat in the cycle it is accepted and pushes a job into a
// P_JOB_DEPTH-entry queue, and the back end moves the oldest job into a result register
// when that register is free or being popped. full rises only when the job queue is
// full, which happens only while the output side is not popping.
// Write side_select (index 0) and window_ticks (index 1) through the configuration
// channel only while the unit is idle; that channel is always ready.
`include "framed_mecanum_drive_command_unit_macros.svh"
module framed_mecanum_drive_command_unit
    import fmdu_pkg::*;
#(
    parameter int P_JOB_DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input beats
    input  logic              push,
    output logic              full,
    input  logic              i_command,
    input  logic        [7:0] i_rx_byte,
    // result beats
    output logic              empty,
    input  logic              pop,
    output logic              o_event_kind,
    output logic signed [7:0] o_forward_axis,
    output logic signed [7:0] o_lateral_axis,
    output logic signed [7:0] o_rotation_axis,
    output logic        [1:0] o_motor_a_dir,
    output logic        [7:0] o_motor_a_duty,
    output logic        [1:0] o_motor_b_dir,
    output logic        [7:0] o_motor_b_duty,
    output logic        [1:0] o_lift_drive,
    // configuration writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic        [3:0] i_cfg_data
);

    logic       r_side_select;
    logic [3:0] r_window_ticks;
    logic       accept;
    logic       job_push, job_valid, job_take, res_valid;
    t_job       front_job, head_job;
    t_result    result;

    // Configuration registers: always ready, written in place.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_select  <= C_SIDE_RIGHT;
            r_window_ticks <= C_WINDOW_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                C_REG_SIDE:   r_side_select  <= i_cfg_data[0];
                C_REG_WINDOW: r_window_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold input beats while the job queue has no room.
    assign accept = push && !full;

    fmdu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_command      (i_command),
        .i_rx_byte      (i_rx_byte),
        .i_window_ticks (r_window_ticks),
        .o_job_push     (job_push),
        .o_job          (front_job)
    );

    fmdu_queue #(
        .DEPTH (P_JOB_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .i_take  (job_take),
        .o_valid (job_valid),
        .o_full  (full),
        .o_job   (head_job)
    );

    fmdu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (job_valid),
        .i_job         (head_job),
        .i_side_select (r_side_select),
        .i_pop         (pop),
        .o_job_take    (job_take),
        .o_valid       (res_valid),
        .o_result      (result)
    );

    // Drive the result ports from the back end's result register.
    assign empty           = !res_valid;
    assign o_event_kind    = result.event_kind;
    assign o_forward_axis  = result.forward_axis;
    assign o_lateral_axis  = result.lateral_axis;
    assign o_rotation_axis = result.rotation_axis;
    assign o_motor_a_dir   = result.motor_a_dir;
    assign o_motor_a_duty  = result.motor_a_duty;
    assign o_motor_b_dir   = result.motor_b_dir;
    assign o_motor_b_duty  = result.motor_b_duty;
    assign o_lift_drive    = result.lift_drive;

    // A link-lost notice carries nothing but its kind.
    `FMDU_ASSERT_NEVER(a_loss_clean, i_clk, i_rst_n,
        !empty && o_event_kind == C_KIND_LOSS && (o_forward_axis != '0
        || o_motor_a_duty != '0 || o_motor_b_duty != '0 || o_lift_drive != C_LIFT_OFF),
        "loss notice carries drive data")

    // A lift command stops both wheels and runs motor B at the lift duty.
    `FMDU_ASSERT_NEVER(a_lift_shape, i_clk, i_rst_n,
        !empty && o_lift_drive != C_LIFT_OFF && (o_motor_a_dir != C_DIR_OFF
        || o_motor_b_dir != C_DIR_OFF || o_motor_b_duty != C_LIFT_DUTY_B),
        "lift command with wheels running")

    // A plain drive command always gives both wheels a direction.
    `FMDU_ASSERT_NEVER(a_drive_dir, i_clk, i_rst_n,
        !empty && o_event_kind == C_KIND_DRIVE && o_lift_drive == C_LIFT_OFF
        && (o_motor_a_dir == C_DIR_OFF || o_motor_b_dir == C_DIR_OFF),
        "drive command without wheel direction")

    // A waiting job with the result register free reaches it at the next edge.
    `FMDU_ASSERT_NEXT(a_job_flows, i_clk, i_rst_n, job_valid && empty, !empty,
        "job lost between front and back")

endmodule

@@ rtl/core/fmdu_front.sv @@
// Front end: frame assembly, link window tracking and job classification.
module fmdu_front
    import fmdu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_command,
    input  logic [7:0] i_rx_byte,
    input  logic [3:0] i_window_ticks,
    output logic       o_job_push,
    output t_job       o_job
);

    logic [1:0] r_pos,      n_pos;
    logic       r_sync,     n_sync;
    logic [7:0] r_fwd_byte, n_fwd_byte;
    logic [7:0] r_lat_byte, n_lat_byte;
    logic       r_link,     n_link;
    logic       r_loss,     n_loss;
    logic [3:0] r_tick,     n_tick;

    always_comb begin
        n_pos      = r_pos;
        n_sync     = r_sync;
        n_fwd_byte = r_fwd_byte;
        n_lat_byte = r_lat_byte;
        n_link     = r_link;
        n_loss     = r_loss;
        n_tick     = r_tick;
        o_job_push = 1'b0;
        o_job.kind     = C_KIND_DRIVE;
        o_job.fwd_byte = r_fwd_byte;
        o_job.lat_byte = r_lat_byte;
        o_job.rot_byte = i_rx_byte;
        if (i_accept) begin
            if (i_command == C_CMD_TICK) begin
                if (r_tick < i_window_ticks) begin
                    n_tick = r_tick + 4'd1;
                end else begin
                    n_tick = '0;
                    if (!r_link && !r_loss) begin
                        n_loss     = 1'b1;
                        o_job_push = 1'b1;
                        o_job.kind = C_KIND_LOSS;
                    end else begin
                        n_link = 1'b0;
                    end
                end
            end else if (i_rx_byte == C_SYNC_BYTE) begin
                // Restart the frame: the next byte is the forward axis.
                n_sync = 1'b1;
                n_pos  = 2'd1;
            end else begin
                case (r_pos)
                    2'd0: n_sync     = 1'b0;
                    2'd1: n_fwd_byte = i_rx_byte;
                    2'd2: n_lat_byte = i_rx_byte;
                    default: ;
                endcase
                n_pos = r_pos + 2'd1;
                if (r_pos == C_LAST_POS && r_sync) begin
                    n_link     = 1'b1;
                    n_loss     = 1'b0;
                    o_job_push = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_sync <= 1'b0;
            r_link <= 1'b0;
            r_loss <= 1'b0;
            r_tick <= '0;
        end else begin
            r_pos  <= n_pos;
            r_sync <= n_sync;
            r_link <= n_link;
            r_loss <= n_loss;
            r_tick <= n_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_byte <= n_fwd_byte;
        r_lat_byte <= n_lat_byte;
    end

endmodule

@@ rtl/core/fmdu_queue.sv @@
// Short job queue between the front end and the drive back end.
module fmdu_queue
    import fmdu_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_take,
    output logic o_valid,
    output logic o_full,
    output t_job o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PW'(1);
            end
            if (i_take) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PW'(1);
            end
            case ({i_push, i_take})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/core/fmdu_back.sv @@
// Back end: lift decode, mecanum sums and the result register.
module fmdu_back
    import fmdu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_job_valid,
    input  t_job    i_job,
    input  logic    i_side_select,
    input  logic    i_pop,
    output logic    o_job_take,
    output logic    o_valid,
    output t_result o_result
);

    logic              r_valid;
    t_result           r_result, n_result;
    logic        [7:0] r_held_a, n_held_a;
    logic signed [9:0] fwd, lat, rot, rear, front;
    logic        [8:0] rear_mag, front_mag;
    logic              lift_up, lift_down;

    function automatic logic [8:0] mag_of(input logic signed [9:0] s);
        logic [9:0] m;
        begin
            m = s[9] ? 10'(-s) : 10'(s);
            mag_of = (m[8:0] > C_MAG_LIMIT) ? C_MAG_LIMIT : m[8:0];
        end
    endfunction

    assign o_job_take = i_job_valid && (!r_valid || i_pop);
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_comb begin
        fwd = $signed({2'b00, i_job.fwd_byte}) - $signed(C_AXIS_BIAS);
        lat = $signed({2'b00, i_job.lat_byte}) - $signed(C_AXIS_BIAS);
        rot = $signed({2'b00, i_job.rot_byte}) - $signed(C_AXIS_BIAS);
        if (i_side_select == C_SIDE_LEFT) begin
            rear  = fwd - lat + rot;
            front = fwd + lat + rot;
        end else begin
            rear  = fwd + lat - rot;
            front = fwd - lat - rot;
        end
        rear_mag  = mag_of(rear);
        front_mag = mag_of(front);
        lift_up   = (i_job.fwd_byte == C_LIFT_UP_BYTE) && (i_job.lat_byte == C_LIFT_UP_BYTE)
                 && (i_job.rot_byte == C_LIFT_UP_BYTE);
        lift_down = (i_job.fwd_byte == C_LIFT_DOWN_BYTE)
                 && (i_job.lat_byte == C_LIFT_DOWN_BYTE)
                 && (i_job.rot_byte == C_LIFT_DOWN_BYTE);

        n_held_a = r_held_a;
        n_result = '0;
        if (i_job.kind == C_KIND_LOSS) begin
            n_result.event_kind = C_KIND_LOSS;
        end else begin
            n_result.event_kind    = C_KIND_DRIVE;
            n_result.forward_axis  = fwd[7:0];
            n_result.lateral_axis  = lat[7:0];
            n_result.rotation_axis = rot[7:0];
            if (lift_up || lift_down) begin
                n_result.motor_a_dir  = C_DIR_OFF;
                n_result.motor_a_duty = r_held_a;
                n_result.motor_b_dir  = C_DIR_OFF;
                n_result.motor_b_duty = C_LIFT_DUTY_B;
                n_result.lift_drive   = lift_up ? C_LIFT_UP : C_LIFT_DOWN;
            end else begin
                n_result.motor_a_dir  = rear[9] ? C_DIR_REV : C_DIR_FWD;
                n_result.motor_a_duty = {rear_mag[6:0], 1'b0};
                n_result.motor_b_dir  = front[9] ? C_DIR_REV : C_DIR_FWD;
                n_result.motor_b_duty = {front_mag[6:0], 1'b0};
                n_result.lift_drive   = C_LIFT_OFF;
                n_held_a              = n_result.motor_a_duty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_held_a <= '0;
        end else if (o_job_take) begin
            r_valid  <= 1'b1;
            r_held_a <= n_held_a;
        end else if (i_pop) begin
            r_valid  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_take) begin
            r_result <= n_result;
        end
    end

endmodule

@@ sim/framed_mecanum_drive_command_unit_tb.sv @@
// Self-checking bench for the framed mecanum drive command unit: directed table, then random phases.
module framed_mecanum_drive_command_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fmdu_pkg::*;

    localparam real CLK_HALF      = 6.0;
    localparam int  RESET_CYCLES  = 5;
    localparam int  MAX_GAP       = 4;
    // Results go through the job queue and then the result register; settle before touching registers.
    localparam int  SETTLE_CYCLES = 6;
    localparam int  HOLD_CYCLES   = 48;
    localparam int  STALL_LIMIT   = 2000;
    localparam int  PHASE_BEATS   = 85;
    localparam int  PRESSURE_FRMS = 10;

    typedef struct {
        logic       cmd;
        logic [7:0] rx;
        bit         typed;
        t_result    want;
    } t_stim_row;

    // DUT hookup; every input starts at a known value.
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              push        = 1'b0;
    logic              full;
    logic              i_command   = C_CMD_BYTE;
    logic        [7:0] i_rx_byte   = 8'd0;
    logic              empty;
    logic              pop         = 1'b0;
    logic              o_event_kind;
    logic signed [7:0] o_forward_axis;
    logic signed [7:0] o_lateral_axis;
    logic signed [7:0] o_rotation_axis;
    logic        [1:0] o_motor_a_dir;
    logic        [7:0] o_motor_a_duty;
    logic        [1:0] o_motor_b_dir;
    logic        [7:0] o_motor_b_duty;
    logic        [1:0] o_lift_drive;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_index = C_REG_SIDE;
    logic        [3:0] i_cfg_data  = 4'd0;

    // Mirror of the unit's registers and state; the state advances on every accepted beat.
    logic              side_sel;
    logic        [3:0] window_len;
    logic        [1:0] frame_pos;
    logic        [7:0] frame_buf [4];
    logic              link_up;
    logic              loss_sent;
    logic        [3:0] tick_cnt;
    logic        [7:0] held_a_duty;

    // Drive commands and link-lost notices that the unit still owes us, oldest first.
    t_result           pending_cmds [$];
    t_stim_row         directed_rows [$];

    bit                src_calm      = 1'b0;
    int                hold_requests = 0;
    int                beats_sent    = 0;
    int                cfg_writes    = 0;
    int                mismatches    = 0;
    int                results_seen  = 0;
    int                n_drive       = 0;
    int                n_lift        = 0;
    int                n_loss        = 0;
    int                idle_cycles   = 0;

    always #(CLK_HALF) i_clk = ~i_clk;

    framed_mecanum_drive_command_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_command      (i_command),
        .i_rx_byte      (i_rx_byte),
        .empty          (empty),
        .pop            (pop),
        .o_event_kind   (o_event_kind),
        .o_forward_axis (o_forward_axis),
        .o_lateral_axis (o_lateral_axis),
        .o_rotation_axis(o_rotation_axis),
        .o_motor_a_dir  (o_motor_a_dir),
        .o_motor_a_duty (o_motor_a_duty),
        .o_motor_b_dir  (o_motor_b_dir),
        .o_motor_b_duty (o_motor_b_duty),
        .o_lift_drive   (o_lift_drive),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic clear_model();
        side_sel    = C_SIDE_RIGHT;
        window_len  = C_WINDOW_RESET;
        frame_pos   = '0;
        frame_buf   = '{default: 8'd0};
        link_up     = 1'b0;
        loss_sent   = 1'b0;
        tick_cnt    = '0;
        held_a_duty = '0;
    endtask

    // Direction from the sign (zero counts as forward), duty twice the clamped magnitude.
    function automatic void wheel_drive(input int sum, output logic [1:0] dir,
                                        output logic [7:0] duty);
        int mag;
        mag = (sum < 0) ? -sum : sum;
        if (mag > int'(C_MAG_LIMIT)) mag = int'(C_MAG_LIMIT);
        dir  = (sum < 0) ? C_DIR_REV : C_DIR_FWD;
        duty = 8'(2 * mag);
    endfunction

    // Advance the mirrored state by one beat and return the command it produces, if any.
    task automatic mix_wheel_command(input logic cmd, input logic [7:0] rx,
                                     output bit has_cmd, output t_result cmd_out);
        logic [1:0] pos;
        logic [1:0] a_dir, b_dir;
        logic [7:0] a_duty, b_duty;
        int         fwd, lat, rot, rear, front;
        has_cmd = 1'b0;
        cmd_out = '0;
        if (cmd == C_CMD_TICK) begin
            // Count toward the window end; a closing window with no frame reports once.
            if (tick_cnt < window_len) begin
                tick_cnt = tick_cnt + 4'd1;
            end else begin
                tick_cnt = '0;
                if (!link_up && !loss_sent) begin
                    loss_sent          = 1'b1;
                    cmd_out.event_kind = C_KIND_LOSS;
                    has_cmd            = 1'b1;
                end else begin
                    link_up = 1'b0;
                end
            end
            return;
        end
        // Store the byte; a sync byte restarts the frame from position zero.
        pos            = frame_pos;
        frame_buf[pos] = rx;
        if (rx == C_SYNC_BYTE) begin
            frame_buf[0] = C_SYNC_BYTE;
            pos          = '0;
        end
        if (pos != C_LAST_POS) begin
            frame_pos = pos + 2'd1;
            return;
        end
        // Four bytes in: wrap, and drop the frame unless it opened with sync.
        frame_pos = '0;
        if (frame_buf[0] != C_SYNC_BYTE) return;
        link_up   = 1'b1;
        loss_sent = 1'b0;
        fwd = int'(frame_buf[1]) - int'(C_AXIS_BIAS);
        lat = int'(frame_buf[2]) - int'(C_AXIS_BIAS);
        rot = int'(frame_buf[3]) - int'(C_AXIS_BIAS);
        cmd_out.event_kind    = C_KIND_DRIVE;
        cmd_out.forward_axis  = 8'(fwd);
        cmd_out.lateral_axis  = 8'(lat);
        cmd_out.rotation_axis = 8'(rot);
        if (frame_buf[1] == C_LIFT_UP_BYTE && frame_buf[2] == C_LIFT_UP_BYTE &&
            frame_buf[3] == C_LIFT_UP_BYTE) begin
            cmd_out.motor_a_duty = held_a_duty;
            cmd_out.motor_b_duty = C_LIFT_DUTY_B;
            cmd_out.lift_drive   = C_LIFT_UP;
        end else if (frame_buf[1] == C_LIFT_DOWN_BYTE && frame_buf[2] == C_LIFT_DOWN_BYTE &&
                     frame_buf[3] == C_LIFT_DOWN_BYTE) begin
            cmd_out.motor_a_duty = held_a_duty;
            cmd_out.motor_b_duty = C_LIFT_DUTY_B;
            cmd_out.lift_drive   = C_LIFT_DOWN;
        end else begin
            if (side_sel == C_SIDE_LEFT) begin
                rear  = fwd - lat + rot;
                front = fwd + lat + rot;
            end else begin
                rear  = fwd + lat - rot;
                front = fwd - lat - rot;
            end
            wheel_drive(rear, a_dir, a_duty);
            wheel_drive(front, b_dir, b_duty);
            cmd_out.motor_a_dir  = a_dir;
            cmd_out.motor_a_duty = a_duty;
            cmd_out.motor_b_dir  = b_dir;
            cmd_out.motor_b_duty = b_duty;
            cmd_out.lift_drive   = C_LIFT_OFF;
            held_a_duty          = a_duty;
        end
        has_cmd = 1'b1;
    endtask

    function automatic t_result drive_word(input logic kind, input logic [7:0] fwd,
                                           input logic [7:0] lat, input logic [7:0] rot,
                                           input logic [1:0] a_dir, input logic [7:0] a_duty,
                                           input logic [1:0] b_dir, input logic [7:0] b_duty,
                                           input logic [1:0] lift);
        t_result w;
        w.event_kind    = kind;
        w.forward_axis  = fwd;
        w.lateral_axis  = lat;
        w.rotation_axis = rot;
        w.motor_a_dir   = a_dir;
        w.motor_a_duty  = a_duty;
        w.motor_b_dir   = b_dir;
        w.motor_b_duty  = b_duty;
        w.lift_drive    = lift;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Input side: all drives happen at the falling edge, handshakes are
    // sampled at the rising edge.
    // ------------------------------------------------------------------

    // Offer one beat after a random gap; on acceptance queue either the typed
    // expectation or the predicted one.
    task automatic send_beat(input logic cmd, input logic [7:0] rx, input bit typed,
                             input t_result want);
        int      gap;
        bit      has_cmd;
        t_result pred;
        gap = src_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push      = 1'b1;
        i_command = cmd;
        i_rx_byte = rx;
        do @(posedge i_clk); while (full);
        mix_wheel_command(cmd, rx, has_cmd, pred);
        if (typed) pending_cmds.push_back(want);
        else if (has_cmd) pending_cmds.push_back(pred);
        beats_sent++;
        @(negedge i_clk);
    endtask

    // Hold the input low until every owed result has been popped.
    task automatic drain();
        push = 1'b0;
        while (pending_cmds.size() != 0) @(negedge i_clk);
    endtask

    // Write one register once the unit has gone quiet.
    task automatic write_reg(input logic idx, input logic [3:0] val);
        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == C_REG_SIDE) side_sel = val[0];
        else window_len = val;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Axis bytes by flavor: lift codes, near center (small sums), or anything but sync.
    function automatic logic [7:0] axis_byte(input int flavor);
        case (flavor)
            0:       return C_LIFT_UP_BYTE;
            1:       return C_LIFT_DOWN_BYTE;
            2:       return 8'($urandom_range(120, 134));
            default: return 8'($urandom_range(0, int'(C_SYNC_BYTE) - 1));
        endcase
    endfunction

    task automatic send_frame();
        int flavor, i;
        flavor = $urandom_range(0, 9);
        send_beat(C_CMD_BYTE, C_SYNC_BYTE, 1'b0, '0);
        for (i = 0; i < 3; i++) send_beat(C_CMD_BYTE, axis_byte(flavor), 1'b0, '0);
    endtask

    // Mostly well-formed frames with random content; the rest ticks, noise and cut frames.
    task automatic run_phase(input int beats);
        int start, pick, i, cnt;
        start = beats_sent;
        while (beats_sent - start < beats) begin
            if ($urandom_range(0, 19) == 0) src_calm = !src_calm;
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                send_frame();
            end else if (pick < 80) begin
                cnt = $urandom_range(1, 3);
                for (i = 0; i < cnt; i++)
                    send_beat(C_CMD_TICK, 8'($urandom_range(0, 255)), 1'b0, '0);
            end else if (pick < 90) begin
                send_beat(C_CMD_BYTE, 8'($urandom_range(0, 255)), 1'b0, '0);
            end else begin
                // Sync plus a partial frame; whatever comes next picks up from here.
                cnt = $urandom_range(1, 2);
                send_beat(C_CMD_BYTE, C_SYNC_BYTE, 1'b0, '0);
                for (i = 0; i < cnt; i++)
                    send_beat(C_CMD_BYTE, 8'($urandom_range(0, 254)), 1'b0, '0);
            end
        end
    endtask

    task automatic add_row(input logic cmd, input logic [7:0] rx, input bit typed,
                           input t_result want);
        t_stim_row row;
        row.cmd   = cmd;
        row.rx    = rx;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        $display("MISMATCH result %0d %s: got %h expected %h", results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) flag_mismatch(name, got, want);
    endtask

    task automatic check_cmd(input t_result got);
        t_result want;
        if (pending_cmds.size() == 0) begin
            flag_mismatch("unexpected result, kind", 8'(got.event_kind), 8'hxx);
            return;
        end
        want = pending_cmds.pop_front();
        check_field("event_kind", 8'(got.event_kind), 8'(want.event_kind));
        check_field("forward_axis", got.forward_axis, want.forward_axis);
        check_field("lateral_axis", got.lateral_axis, want.lateral_axis);
        check_field("rotation_axis", got.rotation_axis, want.rotation_axis);
        check_field("motor_a_dir", 8'(got.motor_a_dir), 8'(want.motor_a_dir));
        check_field("motor_a_duty", got.motor_a_duty, want.motor_a_duty);
        check_field("motor_b_dir", 8'(got.motor_b_dir), 8'(want.motor_b_dir));
        check_field("motor_b_duty", got.motor_b_duty, want.motor_b_duty);
        check_field("lift_drive", 8'(got.lift_drive), 8'(want.lift_drive));
    endtask

    // Pop results with random stalls and stretches of none; honor hold-off requests
    // by counting the stall here so the sender keeps pushing meanwhile.
    initial begin : result_sink
        int      stall;
        int      holds_done;
        bit      sink_calm;
        t_result got;
        holds_done = 0;
        sink_calm  = 1'b0;
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (hold_requests > holds_done) begin
                pop = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                holds_done++;
            end
            if ($urandom_range(0, 19) == 0) sink_calm = !sink_calm;
            stall = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                pop = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pop = 1'b1;
            do @(posedge i_clk); while (empty);
            got = drive_word(o_event_kind, o_forward_axis, o_lateral_axis, o_rotation_axis,
                             o_motor_a_dir, o_motor_a_duty, o_motor_b_dir, o_motor_b_duty,
                             o_lift_drive);
            check_cmd(got);
            results_seen++;
            if (got.event_kind == C_KIND_LOSS) n_loss++;
            else if (got.lift_drive != C_LIFT_OFF) n_lift++;
            else n_drive++;
            @(negedge i_clk);
        end
    end

    // Watchdog: end the run if nothing moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("framed_mecanum_drive_command_unit_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        int i;
        clear_model();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table, run at the reset settings (right pair, window of nine).
        // Nine ticks only count; the tenth closes a window that saw no frame.
        for (i = 0; i < 9; i++) add_row(C_CMD_TICK, 8'($urandom_range(0, 255)), 1'b0, '0);
        add_row(C_CMD_TICK, 8'hFF, 1'b1,
                drive_word(C_KIND_LOSS, 8'd0, 8'd0, 8'd0, C_DIR_OFF, 8'd0, C_DIR_OFF, 8'd0,
                           C_LIFT_OFF));
        // Largest data bytes: all axes +127, rear full forward, front full reverse.
        add_row(C_CMD_BYTE, C_SYNC_BYTE, 1'b0, '0);
        add_row(C_CMD_BYTE, 8'd254, 1'b0, '0);
        add_row(C_CMD_BYTE, 8'd254, 1'b0, '0);
        add_row(C_CMD_BYTE, 8'd254, 1'b1,
                drive_word(C_KIND_DRIVE, 8'sd127, 8'sd127, 8'sd127, C_DIR_FWD, 8'd254,
                           C_DIR_REV, 8'd254, C_LIFT_OFF));
        // Lift up, then down: drive motors off, front at lift duty, rear duty held.
        add_row(C_CMD_BYTE, C_SYNC_BYTE, 1'b0, '0);
        add_row(C_CMD_BYTE, C_LIFT_UP_BYTE, 1'b0, '0);
        add_row(C_CMD_BYTE, C_LIFT_UP_BYTE, 1'b0, '0);
        add_row(C_CMD_BYTE, C_LIFT_UP_BYTE, 1'b1,
                drive_word(C_KIND_DRIVE, 8'sd124, 8'sd124, 8'sd124, C_DIR_OFF, 8'd254,
                           C_DIR_OFF, C_LIFT_DUTY_B, C_LIFT_UP));
        add_row(C_CMD_BYTE, C_SYNC_BYTE, 1'b0, '0);
        add_row(C_CMD_BYTE, C_LIFT_DOWN_BYTE, 1'b0, '0);
        add_row(C_CMD_BYTE, C_LIFT_DOWN_BYTE, 1'b0, '0);
        add_row(C_CMD_BYTE, C_LIFT_DOWN_BYTE, 1'b1,
                drive_word(C_KIND_DRIVE, 8'sd123, 8'sd123, 8'sd123, C_DIR_OFF, 8'd254,
                           C_DIR_OFF, C_LIFT_DUTY_B, C_LIFT_DOWN));
        // Four zero bytes with no sync: the frame wraps and is dropped.
        for (i = 0; i < 4; i++) add_row(C_CMD_BYTE, 8'd0, 1'b0, '0);
        // Back-to-back sync restarts the frame; centered axes give zero sums.
        add_row(C_CMD_BYTE, C_SYNC_BYTE, 1'b0, '0);
        add_row(C_CMD_BYTE, C_SYNC_BYTE, 1'b0, '0);
        add_row(C_CMD_BYTE, 8'd127, 1'b0, '0);
        add_row(C_CMD_BYTE, 8'd127, 1'b0, '0);
        add_row(C_CMD_BYTE, 8'd127, 1'b1,
                drive_word(C_KIND_DRIVE, 8'd0, 8'd0, 8'd0, C_DIR_FWD, 8'd0, C_DIR_FWD, 8'd0,
                           C_LIFT_OFF));
        foreach (directed_rows[k])
            send_beat(directed_rows[k].cmd, directed_rows[k].rx, directed_rows[k].typed,
                      directed_rows[k].want);

        // Left pair with the longest window.
        write_reg(C_REG_SIDE, {3'd0, C_SIDE_LEFT});
        write_reg(C_REG_WINDOW, 4'd15);
        run_phase(PHASE_BEATS);

        // Right pair, window of one; stop mid-phase until everything drains.
        write_reg(C_REG_SIDE, {3'd0, C_SIDE_RIGHT});
        write_reg(C_REG_WINDOW, 4'd1);
        run_phase(PHASE_BEATS / 2);
        drain();
        run_phase(PHASE_BEATS / 2);

        // Window of zero closes on every tick.
        write_reg(C_REG_SIDE, {3'd0, C_SIDE_LEFT});
        write_reg(C_REG_WINDOW, 4'd0);
        run_phase(PHASE_BEATS);

        write_reg(C_REG_SIDE, {3'd0, C_SIDE_RIGHT});
        write_reg(C_REG_WINDOW, 4'($urandom_range(2, 14)));
        run_phase(PHASE_BEATS);

        // Back-pressure: receiver holds off while frames stream in back to back,
        // so the job queue fills and full must stall the input.
        write_reg(C_REG_SIDE, {3'd0, C_SIDE_LEFT});
        write_reg(C_REG_WINDOW, 4'd3);
        hold_requests++;
        src_calm = 1'b1;
        for (i = 0; i < PRESSURE_FRMS; i++) send_frame();
        run_phase(PHASE_BEATS);

        // Back to the reset window value on the right pair.
        write_reg(C_REG_SIDE, {3'd0, C_SIDE_RIGHT});
        write_reg(C_REG_WINDOW, C_WINDOW_RESET);
        run_phase(PHASE_BEATS);

        // Let the tail drain, then give any stray result time to show up.
        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("run: %0d beats in, %0d results out (%0d drive, %0d lift, %0d link-lost)",
                 beats_sent, results_seen, n_drive, n_lift, n_loss);
        $display("run: %0d register writes, both wheel pairs, windows 0..15, %0d mismatches",
                 cfg_writes, mismatches);
        if (mismatches == 0) begin
            $display("framed_mecanum_drive_command_unit_tb passed");
        end else begin
            $display("framed_mecanum_drive_command_unit_tb failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/fmdu_pkg.sv
rtl/core/fmdu_front.sv
rtl/core/fmdu_queue.sv
rtl/core/fmdu_back.sv
rtl/core/framed_mecanum_drive_command_unit.sv
sim/framed_mecanum_drive_command_unit_tb.sv
